[src/qhs_pkg.sv]
// ----------------------------------------------------------------------------
// qhs_pkg
// Shared types, register codes and fixed-point helpers for the int8
// hard-swish pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qhs_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_INPUT_OFFSET  = 3'd0,
    REG_OUTPUT_OFFSET = 3'd1,
    REG_OUT_MULT      = 3'd2,
    REG_OUT_EXP       = 3'd3,
    REG_GATE_MULT     = 3'd4,
    REG_GATE_EXP      = 3'd5
  } qhs_reg_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 15;

  // register file contents passed to every pipeline module
  typedef struct packed {
    logic signed [7:0] input_offset;
    logic signed [7:0] output_offset;
    logic [14:0]       out_mult;
    logic signed [4:0] out_exp;
    logic [14:0]       gate_mult;
    logic signed [4:0] gate_exp;
  } qhs_cfg_t;

  // clamp to int16
  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // saturating left shift, shift amount 0..15
  function automatic logic signed [15:0] sat_shl16(input logic signed [15:0] x,
                                                    input logic [3:0] s);
    logic signed [31:0] w;
    w = 32'(x) <<< s;
    return sat16(34'(w));
  endfunction

  // finish of the rounding doubling high multiply (Q15) from the raw product
  function automatic logic signed [15:0] hm_fin(input logic signed [31:0] p);
    logic signed [32:0] t;
    t = 33'(p) + 33'sd16384;
    return sat16(34'(t >>> 15));
  endfunction

  // rounding right shift, half away from zero, shift amount 0..16
  function automatic logic signed [15:0] round_shr16(input logic signed [15:0] x,
                                                      input logic [4:0] e);
    logic [16:0]        mask17;
    logic [15:0]        mask;
    logic [15:0]        rem;
    logic [16:0]        thr;
    logic signed [16:0] q;
    mask17 = (17'd1 << e) - 17'd1;
    mask   = mask17[15:0];
    rem    = x & mask;
    thr    = {2'b00, mask[15:1]} + {16'd0, x[15]};
    q      = 17'(x >>> e);
    if ({1'b0, rem} > thr) begin
      q = q + 17'sd1;
    end
    return sat16(34'(q));
  endfunction

endpackage

[src/qhs_scale.sv]
// ----------------------------------------------------------------------------
// qhs_scale
// Stages 1-2: zero point removal, widening to Q15 and the gate pre-shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qhs_scale (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qhs_pkg::qhs_cfg_t       cfg,
  input  logic                    in_vld,
  input  logic signed [7:0]       in_act,
  output logic                    out_vld,
  output logic signed [15:0]      out_hires,
  output logic signed [15:0]      out_gate
);
  import qhs_pkg::*;

  logic                vld1_r, vld2_r;
  logic signed [15:0]  hires1_r, hires2_r, gate2_r;
  logic signed [8:0]   diff;
  logic signed [15:0]  hires_nxt;
  logic signed [15:0]  gate_nxt;

  // activation minus zero point, times 128 (never saturates)
  always_comb begin
    diff      = 9'(in_act) - 9'(cfg.input_offset);
    hires_nxt = {diff[8:0], 7'd0};
  end

  // left shift by exponent-1 when the gate exponent is positive
  always_comb begin
    if (cfg.gate_exp > 5'sd0) begin
      gate_nxt = sat_shl16(hires1_r, 4'(cfg.gate_exp - 5'sd1));
    end else begin
      gate_nxt = hires1_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    hires1_r <= hires_nxt;
    hires2_r <= hires1_r;
    gate2_r  <= gate_nxt;
  end

  assign out_vld   = vld2_r;
  assign out_hires = hires2_r;
  assign out_gate  = gate2_r;

endmodule

[src/qhs_mix.sv]
// ----------------------------------------------------------------------------
// qhs_mix
// Stages 3-4: output and gate multiplies, gate post-scaling and mapping
// of the gate to 0..32767.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qhs_mix (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qhs_pkg::qhs_cfg_t       cfg,
  input  logic                    in_vld,
  input  logic signed [15:0]      in_hires,
  input  logic signed [15:0]      in_gate,
  output logic                    out_vld,
  output logic signed [15:0]      out_pre,
  output logic [14:0]             out_gate
);
  import qhs_pkg::*;

  logic                vld3_r, vld4_r;
  logic signed [31:0]  prod_o_r, prod_g_r;
  logic signed [15:0]  pre4_r;
  logic [14:0]         gate4_r;
  logic signed [15:0]  g1, g2;
  logic [4:0]          g_rsh;

  // raw products, multipliers are non-negative
  always_ff @(posedge clk) begin
    prod_o_r <= in_hires * signed'({1'b0, cfg.out_mult});
    prod_g_r <= in_gate * signed'({1'b0, cfg.gate_mult});
  end

  // gate rounding, exponent post-scaling, then (g + 32768) / 2
  always_comb begin
    g1    = hm_fin(prod_g_r);
    g_rsh = 5'(-cfg.gate_exp);
    if (cfg.gate_exp > 5'sd0) begin
      g2 = sat_shl16(g1, 4'd1);
    end else if (cfg.gate_exp < 5'sd0) begin
      g2 = round_shr16(g1, g_rsh);
    end else begin
      g2 = g1;
    end
  end

  always_ff @(posedge clk) begin
    pre4_r  <= hm_fin(prod_o_r);
    gate4_r <= {~g2[15], g2[14:1]};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld3_r <= in_vld;
      vld4_r <= vld3_r;
    end
  end

  assign out_vld  = vld4_r;
  assign out_pre  = pre4_r;
  assign out_gate = gate4_r;

endmodule

[src/qhs_out.sv]
// ----------------------------------------------------------------------------
// qhs_out
// Stages 5-7: gate times output branch, output exponent rescale, zero
// point and int8 clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qhs_out (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qhs_pkg::qhs_cfg_t       cfg,
  input  logic                    in_vld,
  input  logic signed [15:0]      in_pre,
  input  logic [14:0]             in_gate,
  output logic                    out_vld,
  output logic signed [7:0]       out_act
);
  import qhs_pkg::*;

  logic                vld5_r, vld6_r, vld7_r;
  logic signed [31:0]  prod_f_r;
  logic signed [15:0]  fin6_r;
  logic signed [7:0]   act7_r;
  logic signed [15:0]  f1, fin_nxt;
  logic [4:0]          o_rsh;
  logic signed [16:0]  sum;
  logic signed [7:0]   act_nxt;

  // final product
  always_ff @(posedge clk) begin
    prod_f_r <= signed'({1'b0, in_gate}) * in_pre;
  end

  // round, then output exponent
  always_comb begin
    f1    = hm_fin(prod_f_r);
    o_rsh = 5'(-cfg.out_exp);
    if (cfg.out_exp < 5'sd0) begin
      fin_nxt = round_shr16(f1, o_rsh);
    end else begin
      fin_nxt = sat_shl16(f1, cfg.out_exp[3:0]);
    end
  end

  // zero point and int8 clip
  always_comb begin
    sum = 17'(fin6_r) + 17'(cfg.output_offset);
    if (sum > 17'sd127) begin
      act_nxt = 8'sd127;
    end else if (sum < -17'sd128) begin
      act_nxt = -8'sd128;
    end else begin
      act_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    fin6_r <= fin_nxt;
    act7_r <= act_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld5_r <= in_vld;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  assign out_vld = vld7_r;
  assign out_act = act7_r;

endmodule

[src/quantized_hardswish_int8.sv]
// ----------------------------------------------------------------------------
// quantized_hardswish_int8
// Int8 hard-swish activation: seven-stage pipeline with a register file
// for zero points, multipliers and exponents.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-----------------------
//  input    | start, busy, in_act_in                 | start && !busy
//  result   | out_valid, out_act_out                 | one-cycle strobe
//  config   | cfg_valid, cfg_ready, cfg_index, _data | cfg_valid && cfg_ready
//
//  one item per cycle; each taken item passes through 7 register stages:
//  widening, gate pre-shift, two multiply ranks each followed by a
//  rounding/rescale stage, and the final int8 clip.
//  busy is never raised and the receiver cannot stall, so valid bits simply
//  shift along with the data.
//  synchronous active-low reset clears the valid bits and the register file
//  to 0; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantized_hardswish_int8 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [7:0]              in_act_in,
  output logic                           out_valid,
  output logic signed [7:0]              out_act_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qhs_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [qhs_pkg::CfgDataW-1:0]   cfg_data
);
  import qhs_pkg::*;

  qhs_cfg_t            cfg_r;
  logic                accept;
  logic                s2_vld, s4_vld;
  logic signed [15:0]  s2_hires, s2_gate;
  logic signed [15:0]  s4_pre;
  logic [14:0]         s4_gate;

  // pipeline never holds off an item or a config write
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INPUT_OFFSET:  cfg_r.input_offset  <= cfg_data[7:0];
        REG_OUTPUT_OFFSET: cfg_r.output_offset <= cfg_data[7:0];
        REG_OUT_MULT:      cfg_r.out_mult      <= cfg_data[14:0];
        REG_OUT_EXP:       cfg_r.out_exp       <= cfg_data[4:0];
        REG_GATE_MULT:     cfg_r.gate_mult     <= cfg_data[14:0];
        REG_GATE_EXP:      cfg_r.gate_exp      <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // stages 1-2
  qhs_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_vld    (accept),
    .in_act    (in_act_in),
    .out_vld   (s2_vld),
    .out_hires (s2_hires),
    .out_gate  (s2_gate)
  );

  // stages 3-4
  qhs_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vld   (s2_vld),
    .in_hires (s2_hires),
    .in_gate  (s2_gate),
    .out_vld  (s4_vld),
    .out_pre  (s4_pre),
    .out_gate (s4_gate)
  );

  // stages 5-7
  qhs_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (s4_vld),
    .in_pre  (s4_pre),
    .in_gate (s4_gate),
    .out_vld (out_valid),
    .out_act (out_act_out)
  );

endmodule
